/* sv/sorted_priority_queue_unit_macros.svh */
// Assertion macros shared by the priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/spq_pkg.sv */
// Shared types and constants of the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY_DEF = 8;
    localparam int DATA_W       = 32;
    localparam int FILL_W       = 4;
    localparam int STATUS_W     = 2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam logic MODE_HIGH_FIRST = 1'b0;
    localparam logic MODE_LOW_FIRST  = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic enq;
        logic deq;
        logic mode;
    } t_cell_ctrl;

endpackage

/* sv/spq_req_if.sv */
// Request channel of the priority queue: operation, data and priority.
interface spq_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  func;
    logic signed [spq_pkg::DATA_W-1:0]     item_value;
    logic signed [spq_pkg::DATA_W-1:0]     item_priority;

    modport source (output valid, output func, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input func, input item_value, input item_priority,
                    output ready);
endinterface

/* sv/spq_rsp_if.sv */
// Response channel of the priority queue: status, head entry and fill count.
interface spq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [spq_pkg::STATUS_W-1:0]          status;
    logic signed [spq_pkg::DATA_W-1:0]     head_value;
    logic signed [spq_pkg::DATA_W-1:0]     head_priority;
    logic [spq_pkg::FILL_W-1:0]            fill_count;

    modport source (output valid, output status, output head_value, output head_priority,
                    output fill_count, input ready);
    modport sink   (input valid, input status, input head_value, input head_priority,
                    input fill_count, output ready);
endinterface

/* sv/spq_cell.sv */
// One slot of the sorted chain: compares, holds, or shifts toward a neighbor.
module spq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_entry     i_new,
    input  spq_pkg::t_entry     i_left,
    input  logic                i_left_valid,
    input  logic                i_keep_lo,
    input  spq_pkg::t_entry     i_right,
    input  logic                i_right_valid,
    input  logic                i_keep_hi,
    output spq_pkg::t_entry     o_entry,
    output logic                o_valid,
    output logic                o_keep
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            r_valid;
    logic            n_valid;
    logic            w_served;

    // The new entry goes ahead of this one only if it is strictly better.
    assign w_served = (i_ctrl.mode == spq_pkg::MODE_LOW_FIRST) ? (i_new.prio < r_entry.prio)
                                                                : (i_new.prio > r_entry.prio);
    assign o_keep   = (r_valid && !w_served) || i_keep_hi;

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctrl.enq) begin
            if (!o_keep) begin
                n_entry = i_keep_lo ? i_new : i_left;
                n_valid = r_valid | i_left_valid;
            end
        end else if (i_ctrl.deq) begin
            n_entry = i_right;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

/* sv/sorted_priority_queue_unit.sv */
// A result beat is valid in the cycle after its request beat is accepted.
// Throughput: one request per cycle while ready is high; all cells compare and shift in that same cycle.
// Ready is high while the result register is empty or its beat is being taken.
// Synchronous active-low reset empties the queue, empties the result register
// and sets the order mode to larger priority first; no clearing pass is needed.
`include "sorted_priority_queue_unit_macros.svh"

module sorted_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    spq_req_if.sink    i_req,
    spq_rsp_if.source  o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                 r_mode;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    logic [spq_pkg::STATUS_W-1:0]     r_status;
    logic signed [spq_pkg::DATA_W-1:0] r_head_value;
    logic signed [spq_pkg::DATA_W-1:0] r_head_prio;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    spq_pkg::t_cell_ctrl  w_ctrl;
    spq_pkg::t_entry      w_new;
    spq_pkg::t_entry      w_entry [CAPACITY];
    logic [CAPACITY-1:0]  w_valid;
    logic [CAPACITY-1:0]  w_keep;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);

    assign w_ctrl.enq  = w_accept && (i_req.func == spq_pkg::FUNC_ENQ) && !w_full;
    assign w_ctrl.deq  = w_accept && (i_req.func == spq_pkg::FUNC_DEQ) && !w_empty;
    assign w_ctrl.mode = r_mode;
    assign w_new.value = i_req.item_value;
    assign w_new.prio  = i_req.item_priority;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        spq_pkg::t_entry w_left;
        spq_pkg::t_entry w_right;
        logic            w_left_valid;
        logic            w_keep_lo;
        logic            w_right_valid;
        logic            w_keep_hi;

        if (i == 0) begin : g_first
            assign w_left       = '0;
            assign w_left_valid = 1'b1;
            assign w_keep_lo    = 1'b1;
        end else begin : g_mid_lo
            assign w_left       = w_entry[i-1];
            assign w_left_valid = w_valid[i-1];
            assign w_keep_lo    = w_keep[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_right       = '0;
            assign w_right_valid = 1'b0;
            assign w_keep_hi     = 1'b0;
        end else begin : g_mid_hi
            assign w_right       = w_entry[i+1];
            assign w_right_valid = w_valid[i+1];
            assign w_keep_hi     = w_keep[i+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_new         (w_new),
            .i_left        (w_left),
            .i_left_valid  (w_left_valid),
            .i_keep_lo     (w_keep_lo),
            .i_right       (w_right),
            .i_right_valid (w_right_valid),
            .i_keep_hi     (w_keep_hi),
            .o_entry       (w_entry[i]),
            .o_valid       (w_valid[i]),
            .o_keep        (w_keep[i])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.enq) begin
            n_count = r_count + CW'(1);
        end else if (w_ctrl.deq) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= spq_pkg::MODE_HIGH_FIRST;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            if (i_req.func == spq_pkg::FUNC_ENQ) begin
                r_status     <= w_full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
                r_head_value <= '0;
                r_head_prio  <= '0;
            end else if (w_empty) begin
                r_status     <= spq_pkg::ST_EMPTY;
                r_head_value <= '0;
                r_head_prio  <= '0;
            end else begin
                r_status     <= spq_pkg::ST_DONE;
                r_head_value <= w_entry[0].value;
                r_head_prio  <= w_entry[0].prio;
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.head_value    = r_head_value;
    assign o_rsp.head_priority = r_head_prio;
    assign o_rsp.fill_count    = spq_pkg::FILL_W'(r_count);

    `SPQ_ASSERT_IMP(a_valid_matches_count, i_clk, i_rst_n, 1'b1, $countones(w_valid) == int'(r_count), "valid cells disagree with count")
    `SPQ_ASSERT_NXT(a_deq_drops_count, i_clk, i_rst_n, w_ctrl.deq, r_count == $past(r_count) - CW'(1), "dequeue did not remove one entry")
    `SPQ_ASSERT_NXT(a_full_refused, i_clk, i_rst_n, w_accept && (i_req.func == spq_pkg::FUNC_ENQ) && w_full, (r_status == spq_pkg::ST_FULL) && (r_count == $past(r_count)), "full enqueue not refused")

endmodule
